### sv/gls_pkg.sv
// Shared types, constants and helper functions for the Gaussian line sum block.
// No dependencies; the other files that use it refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package gls_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int DATA_W        = 32;
    localparam int IDX_W         = 4;
    localparam int NUSE_W        = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_LINES_DEF = 16;
    localparam int LINE_CAP      = 16;

    // serial divider geometry
    localparam int DIV_W = 54;
    localparam int DEN_W = 31;

    localparam logic [29:0] Q30_LN2  = 30'd744261118;
    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [19:0] XL_LIM   = 20'(6 << FRAC_BITS);
    localparam logic [21:0] T_LIM    = 22'(32 << FRAC_BITS);
    localparam logic [30:0] E_ROUND  = 31'(1 << (29 - FRAC_BITS));
    localparam logic [5:0]  K_LIM    = 6'd62;
    localparam logic signed [31:0] ONE_Q = 32'(1 << FRAC_BITS);
    // floor(2^46 / Q30_LN2); t * K_RECIP >> 32 is t30 div LN2 or one below
    localparam logic [16:0] K_RECIP  = 17'd94548;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUSE   = 2'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;
    localparam logic KIND_LINE  = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    typedef struct packed {
        logic                     is_eval;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] amp;
        logic signed [DATA_W-1:0] cen;
        logic signed [DATA_W-1:0] wid;
        logic signed [DATA_W-1:0] x;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] offset;
        logic signed [DATA_W-1:0] slope;
        logic [NUSE_W-1:0]        nuse;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DEN_W-1:0] rem;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // floor((2^32 - 1) / j); one correction step after the multiply
    function automatic logic [31:0] recip(input logic [2:0] j);
        logic [31:0] res;
        case (j)
            3'd1:    res = 32'd4294967295;
            3'd2:    res = 32'd2147483647;
            3'd3:    res = 32'd1431655765;
            3'd4:    res = 32'd1073741823;
            3'd5:    res = 32'd858993459;
            3'd6:    res = 32'd715827882;
            default: res = 32'd0;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

### sv/gls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gls_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### sv/gls_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gls_pkg (request/response structs, widths).
`timescale 1ns / 1ps
`default_nettype none
module gls_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gls_pkg::t_div_req i_req,
    output gls_pkg::t_div_rsp      o_rsp
);
    localparam int CW = $clog2(gls_pkg::DIV_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic [gls_pkg::DIV_W-1:0]   r_quo;
    logic [gls_pkg::DEN_W-1:0]   r_rem;
    logic [gls_pkg::DEN_W-1:0]   r_den;
    logic [gls_pkg::DEN_W:0]     shifted;
    logic                        fits;

    assign shifted = {r_rem, r_quo[gls_pkg::DIV_W-1]};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(gls_pkg::DIV_W - 1);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= fits ? gls_pkg::DEN_W'(shifted - {1'b0, r_den})
                          : shifted[gls_pkg::DEN_W-1:0];
            r_quo <= {r_quo[gls_pkg::DIV_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule
`default_nettype wire

### sv/gls_front.sv
// Input side: takes transfers, clamps widths, drops out-of-range loads, and
// queues items in a two-entry FIFO for the back end. Depends on gls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gls_front #(
    parameter int MAX_LINES = gls_pkg::MAX_LINES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_func,
    input  wire logic [gls_pkg::IDX_W-1:0]            i_line_index,
    input  wire logic signed [gls_pkg::DATA_W-1:0]    i_amplitude,
    input  wire logic signed [gls_pkg::DATA_W-1:0]    i_center,
    input  wire logic signed [gls_pkg::DATA_W-1:0]    i_width,
    input  wire logic signed [gls_pkg::DATA_W-1:0]    i_x_value,
    output logic                                      o_head_valid,
    output gls_pkg::t_item                            o_head,
    input  wire logic                                 i_pop
);
    gls_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    gls_pkg::t_item item;
    logic           in_range;
    logic           push;
    logic           pop;

    assign in_range = {5'b0, i_line_index} < 9'(MAX_LINES);

    always_comb begin
        item.is_eval = (i_func == gls_pkg::FUNC_EVAL);
        item.idx     = i_line_index;
        item.amp     = i_amplitude;
        item.cen     = i_center;
        item.wid     = (i_width <= 0) ? 32'sd1 : i_width;
        item.x       = i_x_value;
    end

    assign o_in_ready   = r_cnt != 2'd2;
    assign push         = i_in_valid && o_in_ready && (item.is_eval || in_range);
    assign pop          = i_pop && o_head_valid;
    assign o_head_valid = r_cnt != 2'd0;
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= item;
        end
    end
endmodule
`default_nettype wire

### sv/gls_back.sv
// Execution side: line table, sequencer over lines, shared serial divider,
// exp approximation and output register. Depends on gls_pkg, gls_ram, gls_div.
`timescale 1ns / 1ps
`default_nettype none
module gls_back #(
    parameter int MAX_LINES = gls_pkg::MAX_LINES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire gls_pkg::t_cfg                      i_cfg,
    input  wire logic                               i_head_valid,
    input  wire gls_pkg::t_item                     i_head,
    output logic                                    o_pop,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_kind,
    output logic [gls_pkg::IDX_W-1:0]               o_line_number,
    output logic signed [gls_pkg::DATA_W-1:0]       o_value_first,
    output logic signed [gls_pkg::DATA_W-1:0]       o_value_second,
    output logic signed [gls_pkg::DATA_W-1:0]       o_value_third,
    output logic                                    o_last
);
    localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam logic [4:0] NMAX = (MAX_LINES < gls_pkg::LINE_CAP) ?
                                  5'(MAX_LINES) : 5'(gls_pkg::LINE_CAP);
    localparam int FB = gls_pkg::FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_BASE, S_Y, S_RD, S_DAT, S_XL, S_TSQ, S_KDIV, S_KW, S_KR,
        S_PA, S_PB, S_PC, S_EXP, S_QM, S_D1M, S_D1S, S_D1W, S_D2M, S_D2S,
        S_D2W, S_EMIT, S_TOT
    } t_state;

    t_state                 r_state;
    logic signed [31:0]     r_x;
    logic [4:0]             r_n;
    logic [4:0]             r_i;
    logic signed [63:0]     r_m64;
    logic signed [51:0]     r_y;
    logic signed [31:0]     r_amp;
    logic                   r_neg;
    logic signed [19:0]     r_xl;
    logic [21:0]            r_t;
    logic [37:0]            r_kp;
    logic [30:0]            r_r0;
    logic [5:0]             r_k;
    logic [29:0]            r_r;
    logic [30:0]            r_p;
    logic [2:0]             r_j;
    logic [60:0]            r_pp;
    logic [29:0]            r_v;
    logic [29:0]            r_qe;
    logic [16:0]            r_e;
    logic signed [32:0]     r_q;
    logic signed [54:0]     r_m;
    logic                   r_dneg;
    logic signed [31:0]     r_d1;
    logic signed [31:0]     r_d2;
    // width of the current line, kept for the derivative divisions
    logic [30:0]            r_amp_wid;

    // table access
    logic [95:0]            rdata;
    logic                   ram_we;
    logic [AW+4:0]          waddr_ext;
    logic [AW+4:0]          raddr_ext;
    logic signed [31:0]     rd_amp;
    logic signed [31:0]     rd_cen;
    logic [31:0]            rd_wid;

    gls_pkg::t_div_req      div_req;
    gls_pkg::t_div_rsp      div_rsp;

    // datapath
    logic signed [32:0]     diff;
    logic [32:0]            diff_mag;
    logic [gls_pkg::DIV_W-1:0] xl_mag;
    logic signed [39:0]     t_prod;
    logic [38:0]            k_prod;
    logic [35:0]            k_ln2;
    logic [35:0]            t30_val;
    logic [35:0]            rem0;
    logic [29:0]            pv;
    logic [61:0]            pq_prod;
    logic [32:0]            pc_qj;
    logic [32:0]            pc_rem;
    logic [29:0]            pc_quo;
    logic [30:0]            e_sum;
    logic [16:0]            e_val;
    logic signed [49:0]     q_prod;
    logic signed [52:0]     d1_prod;
    logic signed [55:0]     d2_prod;
    logic [54:0]            m_mag;
    logic signed [54:0]     dq_signed;
    logic                   out_free;
    logic                   emit_fire;

    assign rd_amp = rdata[95:64];
    assign rd_cen = rdata[63:32];
    assign rd_wid = rdata[31:0];

    assign ram_we    = (r_state == S_IDLE) && i_head_valid && !i_head.is_eval;
    assign o_pop     = (r_state == S_IDLE) && i_head_valid;
    assign waddr_ext = (AW+5)'(i_head.idx);
    assign raddr_ext = (AW+5)'(r_i);

    gls_ram #(.WIDTH(96), .DEPTH(MAX_LINES), .AW(AW)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr_ext[AW-1:0]),
        .i_wdata ({i_head.amp, i_head.cen, i_head.wid}),
        .i_raddr (raddr_ext[AW-1:0]),
        .o_rdata (rdata)
    );

    gls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign diff     = {r_x[31], r_x} - {rd_cen[31], rd_cen};
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    assign xl_mag   = div_rsp.quo;
    assign t_prod   = r_xl * r_xl;
    // range reduction by ln2: reciprocal estimate, then one fix-up step
    assign k_prod   = r_t * gls_pkg::K_RECIP;
    assign k_ln2    = r_kp[37:32] * gls_pkg::Q30_LN2;
    assign t30_val  = {r_t, 14'b0};
    assign rem0     = t30_val - k_ln2;
    assign pv       = r_pp[59:30];
    assign pq_prod  = pv * gls_pkg::recip(r_j);
    assign pc_qj    = 33'(r_qe) * 33'(r_j);
    assign pc_rem   = 33'(r_v) - pc_qj;
    assign pc_quo   = (pc_rem >= 33'(r_j)) ? r_qe + 30'd1 : r_qe;
    assign e_sum    = (r_p >> r_k) + gls_pkg::E_ROUND;
    assign e_val    = (r_k >= gls_pkg::K_LIM) ? 17'd0 : e_sum[30-FB+16:30-FB];
    assign q_prod   = r_amp * $signed({1'b0, r_e});
    assign d1_prod  = r_q * r_xl;
    assign d2_prod  = r_q * $signed({1'b0, r_t});
    assign m_mag    = r_m[54] ? 55'(-r_m) : 55'(r_m);
    assign dq_signed = r_dneg ? -$signed({1'b0, div_rsp.quo})
                              : $signed({1'b0, div_rsp.quo});
    assign out_free = !o_out_valid || i_out_ready;
    assign emit_fire = out_free && ((r_state == S_EMIT) || (r_state == S_TOT));

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = rd_wid[30:0];
        case (r_state)
            S_DAT: begin
                div_req.start = 1'b1;
                div_req.num   = {4'b0, diff_mag, 17'b0};
            end
            S_D1S, S_D2S: begin
                div_req.start = 1'b1;
                div_req.num   = m_mag[53:0];
                div_req.den   = r_amp_wid;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (emit_fire) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head_valid && i_head.is_eval) begin
                        r_x     <= i_head.x;
                        r_n     <= (i_cfg.nuse > NMAX) ? NMAX : i_cfg.nuse;
                        r_i     <= 5'd0;
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    r_m64   <= i_cfg.slope * r_x;
                    r_state <= S_Y;
                end
                S_Y: begin
                    r_y     <= 52'(i_cfg.offset) + 52'($signed(r_m64[63:FB]));
                    r_state <= (r_n == 5'd0) ? S_TOT : S_RD;
                end
                S_RD: begin
                    r_state <= S_DAT;
                end
                S_DAT: begin
                    r_amp     <= rd_amp;
                    r_amp_wid <= rd_wid[30:0];
                    r_neg     <= diff[32];
                    r_state   <= S_XL;
                end
                S_XL: begin
                    if (div_rsp.done) begin
                        if (xl_mag < 54'(gls_pkg::XL_LIM)) begin
                            r_xl    <= r_neg ? -$signed(xl_mag[19:0])
                                             : $signed(xl_mag[19:0]);
                            r_state <= S_TSQ;
                        end else begin
                            r_e     <= 17'd0;
                            r_q     <= '0;
                            r_d1    <= '0;
                            r_d2    <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_TSQ: begin
                    r_t     <= t_prod[37:FB];
                    r_state <= S_KDIV;
                end
                S_KDIV: begin
                    if (r_t >= gls_pkg::T_LIM) begin
                        r_e     <= 17'd0;
                        r_q     <= '0;
                        r_d1    <= '0;
                        r_d2    <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_kp    <= k_prod[37:0];
                        r_state <= S_KW;
                    end
                end
                S_KW: begin
                    r_k     <= r_kp[37:32];
                    r_r0    <= rem0[30:0];
                    r_state <= S_KR;
                end
                S_KR: begin
                    if (r_r0 >= {1'b0, gls_pkg::Q30_LN2}) begin
                        r_k <= r_k + 6'd1;
                        r_r <= 30'(r_r0 - {1'b0, gls_pkg::Q30_LN2});
                    end else begin
                        r_r <= r_r0[29:0];
                    end
                    r_p     <= gls_pkg::Q30_ONE;
                    r_j     <= 3'd6;
                    r_state <= S_PA;
                end
                S_PA: begin
                    r_pp    <= r_r * r_p;
                    r_state <= S_PB;
                end
                S_PB: begin
                    r_v     <= pv;
                    r_qe    <= pq_prod[61:32];
                    r_state <= S_PC;
                end
                S_PC: begin
                    r_p <= gls_pkg::Q30_ONE - 31'(pc_quo);
                    r_j <= r_j - 3'd1;
                    r_state <= (r_j == 3'd1) ? S_EXP : S_PA;
                end
                S_EXP: begin
                    r_e <= e_val;
                    if (e_val == 17'd0) begin
                        r_q     <= '0;
                        r_d1    <= '0;
                        r_d2    <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_QM;
                    end
                end
                S_QM: begin
                    r_q     <= q_prod[48:FB];
                    r_state <= S_D1M;
                end
                S_D1M: begin
                    r_m     <= {d1_prod, 2'b00};
                    r_state <= S_D1S;
                end
                S_D1S: begin
                    r_dneg  <= r_m[54];
                    r_state <= S_D1W;
                end
                S_D1W: begin
                    if (div_rsp.done) begin
                        r_d1    <= gls_pkg::sat32(64'(dq_signed));
                        r_state <= S_D2M;
                    end
                end
                S_D2M: begin
                    r_m     <= {d2_prod[53:0], 1'b0};
                    r_state <= S_D2S;
                end
                S_D2S: begin
                    r_dneg  <= r_m[54];
                    r_state <= S_D2W;
                end
                S_D2W: begin
                    if (div_rsp.done) begin
                        r_d2    <= gls_pkg::sat32(64'(dq_signed));
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        o_kind         <= gls_pkg::KIND_LINE;
                        o_line_number  <= r_i[3:0];
                        o_value_first  <= 32'(r_e);
                        o_value_second <= r_d1;
                        o_value_third  <= r_d2;
                        o_last         <= 1'b0;
                        r_y            <= r_y + 52'(r_q);
                        r_i            <= r_i + 5'd1;
                        r_state        <= (r_i + 5'd1 == r_n) ? S_TOT : S_RD;
                    end
                end
                S_TOT: begin
                    if (out_free) begin
                        o_kind         <= gls_pkg::KIND_TOTAL;
                        o_line_number  <= '0;
                        o_value_first  <= gls_pkg::sat32(64'(r_y));
                        o_value_second <= gls_pkg::ONE_Q;
                        o_value_third  <= r_x;
                        o_last         <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### sv/gaussian_line_sum_with_gradient.sv
// Top level of the Gaussian line sum with gradient block.
// Depends on gls_pkg, gls_front, gls_back (which holds gls_ram and gls_div).
`timescale 1ns / 1ps
`default_nettype none
// Evaluates offset + slope*x plus a sum of Gaussian lines at x, in signed
// Q16.16, and returns each line's derivatives for least-squares fitting.
// A load transfer (func 0) writes amplitude, center and width into a line
// slot; widths that are zero or negative are stored as one LSB, and slots at
// or beyond MAX_LINES are dropped. An evaluate transfer (func 1) yields one
// result per line in use (kind 0: exp(-xl^2), d/dcenter, d/dwidth) and then
// a final result with last set (kind 1: total y, 1.0, x). All results
// saturate to 32 bits. A slot must be loaded before an evaluation reads it.
// Flow: the front end queues up to two transfers, so input keeps flowing
// while the back end works. A load is written to the table as the back end
// pops it. During an evaluation each line in use runs the 54-step serial
// divider three times (x scaling and two derivatives), a range reduction
// and a series for exp. A line whose exponential is zero skips the
// derivative divisions. Output stalls hold the sequencer. Configuration
// writes are registered and must only happen while the block is idle.
module gaussian_line_sum_with_gradient #(
    parameter int MAX_LINES = gls_pkg::MAX_LINES_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [gls_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [gls_pkg::DATA_W-1:0]            i_cfg_data,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic                                  i_func,
    input  wire logic [gls_pkg::IDX_W-1:0]             i_line_index,
    input  wire logic signed [gls_pkg::DATA_W-1:0]     i_amplitude,
    input  wire logic signed [gls_pkg::DATA_W-1:0]     i_center,
    input  wire logic signed [gls_pkg::DATA_W-1:0]     i_width,
    input  wire logic signed [gls_pkg::DATA_W-1:0]     i_x_value,
    // result channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic                                       o_kind,
    output logic [gls_pkg::IDX_W-1:0]                  o_line_number,
    output logic signed [gls_pkg::DATA_W-1:0]          o_value_first,
    output logic signed [gls_pkg::DATA_W-1:0]          o_value_second,
    output logic signed [gls_pkg::DATA_W-1:0]          o_value_third,
    output logic                                       o_last
);
    gls_pkg::t_cfg  r_cfg;
    gls_pkg::t_item head;
    logic           head_valid;
    logic           pop;

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gls_pkg::CFG_OFFSET: r_cfg.offset <= i_cfg_data;
                gls_pkg::CFG_SLOPE:  r_cfg.slope  <= i_cfg_data;
                gls_pkg::CFG_NUSE:   r_cfg.nuse   <= i_cfg_data[gls_pkg::NUSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: accept, classify, queue.
    gls_front #(.MAX_LINES(MAX_LINES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_line_index (i_line_index),
        .i_amplitude  (i_amplitude),
        .i_center     (i_center),
        .i_width      (i_width),
        .i_x_value    (i_x_value),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Back end: table writes, per-line evaluation, result register.
    gls_back #(.MAX_LINES(MAX_LINES)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head_valid   (head_valid),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_line_number  (o_line_number),
        .o_value_first  (o_value_first),
        .o_value_second (o_value_second),
        .o_value_third  (o_value_third),
        .o_last         (o_last)
    );
endmodule
`default_nettype wire

### sv/gls_checker.sv
// Port-level checks for gaussian_line_sum_with_gradient, bound to the top.
// Depends on gls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gls_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_cfg_we,
    input wire logic [gls_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input wire logic [gls_pkg::DATA_W-1:0]           i_cfg_data,
    input wire logic                                 i_in_valid,
    input wire logic                                 o_in_ready,
    input wire logic                                 i_func,
    input wire logic [gls_pkg::IDX_W-1:0]            i_line_index,
    input wire logic signed [gls_pkg::DATA_W-1:0]    i_amplitude,
    input wire logic signed [gls_pkg::DATA_W-1:0]    i_center,
    input wire logic signed [gls_pkg::DATA_W-1:0]    i_width,
    input wire logic signed [gls_pkg::DATA_W-1:0]    i_x_value,
    input wire logic                                 o_out_valid,
    input wire logic                                 i_out_ready,
    input wire logic                                 o_kind,
    input wire logic [gls_pkg::IDX_W-1:0]            o_line_number,
    input wire logic signed [gls_pkg::DATA_W-1:0]    o_value_first,
    input wire logic signed [gls_pkg::DATA_W-1:0]    o_value_second,
    input wire logic signed [gls_pkg::DATA_W-1:0]    o_value_third,
    input wire logic                                 o_last
);
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_last_is_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == o_kind))
        else $error("last flag and kind disagree");

    a_total_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind |->
            (o_line_number == '0) && (o_value_second == gls_pkg::ONE_Q))
        else $error("total result malformed");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kind |->
            !o_value_first[31] && (o_value_first <= gls_pkg::ONE_Q))
        else $error("line exponential out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value_first)
            && $stable(o_kind))
        else $error("stalled result changed");
endmodule

bind gaussian_line_sum_with_gradient gls_checker u_gls_checker (.*);
`default_nettype wire

### tb/tb_gaussian_line_sum_with_gradient.sv
// Self-checking testbench for gaussian_line_sum_with_gradient.
// Needs gls_pkg and the block's RTL; a scoreboard class predicts every result.
`timescale 1ns / 1ps
module tb_gaussian_line_sum_with_gradient;

    // one result as it leaves the block
    typedef struct packed {
        logic        kind;
        logic [3:0]  line;
        logic [31:0] v1;
        logic [31:0] v2;
        logic [31:0] v3;
        logic        last;
    } t_gauss_result;

    // Scoreboard: holds its own copy of the line table and registers, works
    // out the results of each accepted evaluation and checks them in order.
    class line_sum_board;
        longint         amp_tab[16];
        longint         cen_tab[16];
        longint         wid_tab[16];
        longint         offset;
        longint         slope;
        int unsigned    nuse;
        t_gauss_result  expected_results[$];
        int             mismatches;
        int             checked;
        int             loads;
        int             evals;

        function void set_reg(logic [gls_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
            if (idx == gls_pkg::CFG_OFFSET) begin
                offset = longint'($signed(d));
            end else if (idx == gls_pkg::CFG_SLOPE) begin
                slope = longint'($signed(d));
            end else if (idx == gls_pkg::CFG_NUSE) begin
                nuse = d[4:0];
            end
        endfunction

        function logic [31:0] clamp32(longint v);
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        endfunction

        // exp(-t), t >= 0, Q16.16 in and out; Q30 range reduction plus series
        function longint exp_neg_q(longint t);
            longint t30, k, r, p;
            if (t >= (64'sd32 <<< gls_pkg::FRAC_BITS)) return 0;
            t30 = t <<< (30 - gls_pkg::FRAC_BITS);
            k = t30 / 64'sd744261118;
            r = t30 - k * 64'sd744261118;
            p = 64'sd1 <<< 30;
            for (int j = 6; j >= 1; j--) begin
                p = (64'sd1 <<< 30) - ((r * p) >>> 30) / j;
            end
            if (k >= 62) return 0;
            p = p >>> k;
            return (p + (64'sd1 <<< (29 - gls_pkg::FRAC_BITS))) >>> (30 - gls_pkg::FRAC_BITS);
        endfunction

        function void note_transfer(gls_pkg::t_item it);
            longint x, y, w, xl, t, e, q, d1, d2, lim;
            int unsigned n;
            t_gauss_result r;
            if (it.is_eval == gls_pkg::FUNC_LOAD) begin
                loads++;
                amp_tab[it.idx] = longint'(it.amp);
                cen_tab[it.idx] = longint'(it.cen);
                wid_tab[it.idx] = (longint'(it.wid) <= 0) ? 1 : longint'(it.wid);
                return;
            end
            evals++;
            x = longint'(it.x);
            n = (nuse > 16) ? 16 : nuse;
            lim = 64'sd6 <<< gls_pkg::FRAC_BITS;
            y = offset + ((slope * x) >>> gls_pkg::FRAC_BITS);
            for (int i = 0; i < n; i++) begin
                w = wid_tab[i];
                xl = ((x - cen_tab[i]) * (64'sd1 <<< (gls_pkg::FRAC_BITS + 1))) / w;
                e = 0;
                t = 0;
                d1 = 0;
                d2 = 0;
                if (xl < lim && xl > -lim) begin
                    t = (xl * xl) >>> gls_pkg::FRAC_BITS;
                    e = exp_neg_q(t);
                end
                q = (amp_tab[i] * e) >>> gls_pkg::FRAC_BITS;
                if (e != 0) begin
                    d1 = (q * 4 * xl) / w;
                    d2 = (q * 2 * t) / w;
                end
                y += q;
                r = '{gls_pkg::KIND_LINE, 4'(i), clamp32(e), clamp32(d1), clamp32(d2),
                      1'b0};
                expected_results.push_back(r);
            end
            r = '{gls_pkg::KIND_TOTAL, 4'd0, clamp32(y),
                  clamp32(64'sd1 <<< gls_pkg::FRAC_BITS), clamp32(x), 1'b1};
            expected_results.push_back(r);
        endfunction

        function void check_result(t_gauss_result got);
            t_gauss_result want;
            checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: kind %0d line %0d %h %h %h last %0d",
                             got.kind, got.line, got.v1, got.v2, got.v3, got.last);
                end
                return;
            end
            want = expected_results.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp: kind %0d line %0d %h %h %h last %0d",
                             want.kind, want.line, want.v1, want.v2, want.v3, want.last);
                    $display("         got: kind %0d line %0d %h %h %h last %0d",
                             got.kind, got.line, got.v1, got.v2, got.v3, got.last);
                end
            end
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [gls_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [gls_pkg::DATA_W-1:0]        i_cfg_data = '0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    logic                              i_func = 1'b0;
    logic [gls_pkg::IDX_W-1:0]         i_line_index = '0;
    logic signed [gls_pkg::DATA_W-1:0] i_amplitude = '0;
    logic signed [gls_pkg::DATA_W-1:0] i_center = '0;
    logic signed [gls_pkg::DATA_W-1:0] i_width = '0;
    logic signed [gls_pkg::DATA_W-1:0] i_x_value = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic                              o_kind;
    logic [gls_pkg::IDX_W-1:0]         o_line_number;
    logic signed [gls_pkg::DATA_W-1:0] o_value_first;
    logic signed [gls_pkg::DATA_W-1:0] o_value_second;
    logic signed [gls_pkg::DATA_W-1:0] o_value_third;
    logic                              o_last;

    line_sum_board board = new();

    int burst_left = 0;
    int hold_left = 0;     // long receiver hold-off, counted down by the receiver
    int mode_timer = 0;
    int stall_mode = 0;    // 0 never stall, 1 random, 2 periodic
    int stall_phase = 0;

    gaussian_line_sum_with_gradient dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_line_index   (i_line_index),
        .i_amplitude    (i_amplitude),
        .i_center       (i_center),
        .i_width        (i_width),
        .i_x_value      (i_x_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_line_number  (o_line_number),
        .o_value_first  (o_value_first),
        .o_value_second (o_value_second),
        .o_value_third  (o_value_third),
        .o_last         (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: checks each result transfer, then picks next cycle's ready.
    // Stall modes are picked at random, so some stretches never stall at all.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result('{o_kind, o_line_number, o_value_first, o_value_second,
                                 o_value_third, o_last});
        end
        if (mode_timer == 0) begin
            stall_mode = $urandom_range(2);
            mode_timer = $urandom_range(400, 50);
        end else begin
            mode_timer--;
        end
        stall_phase = (stall_phase + 1) % 7;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_mode == 1) begin
            i_out_ready <= ($urandom_range(3) != 0);
        end else if (stall_mode == 2) begin
            i_out_ready <= (stall_phase < 4);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Timeout: far beyond the slowest legal run.
    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Register write; caller lowers the enable after the last write.
    task automatic write_reg(logic [gls_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        board.set_reg(idx, d);
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] offs, logic [31:0] slp, logic [31:0] nl);
        write_reg(gls_pkg::CFG_OFFSET, offs);
        write_reg(gls_pkg::CFG_SLOPE, slp);
        write_reg(gls_pkg::CFG_NUSE, nl);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One input transfer; valid is left high for a following transfer.
    task automatic send_item(gls_pkg::t_item it);
        i_in_valid <= 1'b1;
        i_func <= it.is_eval;
        i_line_index <= it.idx;
        i_amplitude <= it.amp;
        i_center <= it.cen;
        i_width <= it.wid;
        i_x_value <= it.x;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_transfer(it);
    endtask

    // Sender in bursts with random gaps.
    task automatic offer_item(gls_pkg::t_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(10, 1);
        end
        burst_left--;
        send_item(it);
    endtask

    // Wait until every expected result is in, then let a load finish too.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic gls_pkg::t_item load_item(logic [3:0] idx, logic [31:0] a,
                                                 logic [31:0] c, logic [31:0] w);
        return '{gls_pkg::FUNC_LOAD, idx, a, c, w, $urandom()};
    endfunction

    function automatic gls_pkg::t_item eval_item(logic [31:0] x);
        return '{gls_pkg::FUNC_EVAL, 4'($urandom()), $urandom(), $urandom(), $urandom(), x};
    endfunction

    function automatic gls_pkg::t_item random_load();
        logic [31:0] a, c, w;
        a = ($urandom_range(3) == 0) ? $urandom() : 32'($signed(32'($urandom_range(
                 1 << 22))) - (1 << 21));
        c = ($urandom_range(7) == 0) ? $urandom() : 32'($signed(32'($urandom_range(
                 1 << 21))) - (1 << 20));
        case ($urandom_range(9))
            0:       w = '0;
            1:       w = -$urandom_range(1 << 20);
            2:       w = $urandom();
            default: w = $urandom_range(1 << 20, 1 << 12);
        endcase
        return load_item(4'($urandom()), a, c, w);
    endfunction

    // Mostly x near a loaded line so the exponential is not negligible.
    function automatic gls_pkg::t_item random_eval();
        int     s;
        longint x;
        s = $urandom_range(15);
        if ($urandom_range(4) == 0) begin
            x = longint'($signed(32'($urandom())));
        end else begin
            x = board.cen_tab[s] + (longint'($urandom_range(2000)) - 1000)
                * board.wid_tab[s] / 600;
        end
        if (x > 64'sd2147483647) x = 64'sd2147483647;
        if (x < -64'sd2147483648) x = -64'sd2147483648;
        return eval_item(x[31:0]);
    endfunction

    initial begin
        gls_pkg::t_item it;
        logic [31:0]    nl;
        int             sent;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill every slot first so no unwritten slot is ever read
        set_regs(32'h0001_0000, 32'h0, 32'd0);
        send_item(load_item(4'd0, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000));
        send_item(load_item(4'd1, 32'h8000_0000, 32'h0, 32'h0));           // zero width
        send_item(load_item(4'd2, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000)); // negative
        send_item(load_item(4'd3, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(load_item(4'd4, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000));
        for (int i = 5; i < 16; i++) begin
            send_item(load_item(4'(i), 32'h0003_0000, 32'(i <<< 14), 32'h0002_0000));
        end
        send_item(eval_item(32'h0));          // no lines in use: total only
        drain();
        set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd16);
        send_item(eval_item(32'h7FFF_FFFF));  // saturated total
        send_item(eval_item(32'h8000_0000));
        send_item(eval_item(32'h0000_0000));  // right on two centers
        send_item(eval_item(32'h0000_4000));
        drain();
        set_regs(32'h8000_0000, 32'h8000_0000, 32'd31);   // count capped at sixteen
        send_item(eval_item(32'h0001_8000));
        send_item(eval_item(32'hFFFF_0000));
        drain();

        // random phases, each with its own register setting
        sent = 0;
        for (int ph = 0; sent < 100; ph++) begin
            case (ph % 6)
                0: nl = 32'd1;
                1: nl = $urandom_range(4, 2);
                2: nl = 32'd16;
                3: nl = 32'd0;
                4: nl = $urandom_range(31, 17);
                default: nl = $urandom_range(6);
            endcase
            set_regs(($urandom_range(1)) ? $urandom() : $urandom_range(1 << 18),
                     ($urandom_range(1)) ? $urandom() : $urandom_range(1 << 16), nl);
            if (ph == 2) begin
                // long receiver hold while the sender keeps offering
                hold_left = 3000;
                for (int k = 0; k < 6; k++) begin
                    send_item(random_eval());
                    sent++;
                end
                i_in_valid <= 1'b0;
            end
            for (int k = 0; k < 20; k++) begin
                it = ($urandom_range(2) == 0) ? random_load() : random_eval();
                offer_item(it);
                sent++;
            end
            drain();   // sender pauses until every result is back
        end

        drain();
        $display("Covered %0d loads and %0d evaluations, %0d results checked.",
                 board.loads, board.evals, board.checked);
        if (board.mismatches == 0 && board.expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", board.mismatches,
                     board.expected_results.size());
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

### sim.f
sv/gls_pkg.sv
sv/gls_ram.sv
sv/gls_div.sv
sv/gls_front.sv
sv/gls_back.sv
sv/gaussian_line_sum_with_gradient.sv
sv/gls_checker.sv
tb/tb_gaussian_line_sum_with_gradient.sv
